// ===== rtl/irad_pkg.sv =====
// ----------------------------------------------------------------------------
// irad_pkg: shared constants and helpers for the radix text converter
// Field widths, base limits, ASCII codes and the digit-to-character map.
// ----------------------------------------------------------------------------
package irad_pkg;

    localparam int VALUE_PORT_BITS    = 64;
    localparam int VALUE_BITS_DEFAULT = 64;
    localparam int RADIX_BITS         = 6;
    localparam int DIGIT_BITS         = 6;
    localparam int CHAR_BITS          = 7;

    localparam logic [RADIX_BITS-1:0] BASE_MIN      = 6'd2;
    localparam logic [RADIX_BITS-1:0] BASE_MAX      = 6'd36;
    localparam logic [RADIX_BITS-1:0] BASE_DECIMAL  = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2d;
    localparam logic [CHAR_BITS-1:0] DIGIT_TEN    = 7'd10;

    // Map one digit (0..35) to its ASCII character
    function automatic logic [CHAR_BITS-1:0] digit_char(
        input logic [DIGIT_BITS-1:0] d,
        input logic                  upper
    );
        logic [CHAR_BITS-1:0] d_wide;
        d_wide = {1'b0, d};
        if (d_wide < DIGIT_TEN) begin
            digit_char = CHAR_ZERO + d_wide;
        end
        else begin
            digit_char = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + d_wide - DIGIT_TEN;
        end
    endfunction

endpackage

// ===== rtl/irad_ram.sv =====
// ----------------------------------------------------------------------------
// irad_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irad_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/irad_div.sv =====
// ----------------------------------------------------------------------------
// irad_div: bit-serial restoring divider by a small base
// Divides a VALUE_BITS dividend by a 6-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module irad_div #(
    parameter int VALUE_BITS = irad_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [VALUE_BITS-1:0]           dividend,
    input  logic [irad_pkg::RADIX_BITS-1:0] divisor,
    output logic                            done,
    output logic [VALUE_BITS-1:0]           quotient,
    output logic [irad_pkg::DIGIT_BITS-1:0] remainder
);

    import irad_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;

    logic [DIGIT_BITS:0]   rem_shift;
    logic [DIGIT_BITS:0]   rem_sub;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign rem_sub   = rem_shift - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? rem_sub[DIGIT_BITS-1:0] : rem_shift[DIGIT_BITS-1:0];
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: number to ASCII text in a base from 2 to 36
// Converts one value per item and streams its characters, most significant
// first, with the final character marked.
// ----------------------------------------------------------------------------
// Sequence: a prepare step, then one pass of the shared bit-serial divider per
//   digit, then a RAM read and an output load per character from the digit
//   RAM (after a leading minus sign when the value is negative).
// Throughput: one number at a time; a new number is taken only once the last
//   character of the previous one has been loaded into the output register.
// Reset: rst_n clears the sequencer, the divider control and the output
//   valid flag at once; the digit RAM needs no clearing.
module integer_to_ascii_radix #(
    parameter int VALUE_BITS = irad_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic [irad_pkg::VALUE_PORT_BITS-1:0] value,
    input  logic [irad_pkg::RADIX_BITS-1:0]      radix,
    input  logic                                 upper_case,
    // output channel
    output logic                                 text_valid,
    input  logic                                 text_ready,
    output logic [irad_pkg::CHAR_BITS-1:0]       character,
    output logic                                 last
);

    import irad_pkg::*;

    localparam int ADDR_BITS = $clog2(VALUE_BITS);
    localparam int NDIG_BITS = $clog2(VALUE_BITS + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for an input transfer
    localparam logic [2:0] S_PREP = 3'd1;   // negate if needed, launch divider
    localparam logic [2:0] S_DIV  = 3'd2;   // divider running, one digit each pass
    localparam logic [2:0] S_SIGN = 3'd3;   // present the minus sign
    localparam logic [2:0] S_READ = 3'd4;   // issue a digit RAM read
    localparam logic [2:0] S_SHOW = 3'd5;   // move read digit into the output register

    logic [2:0]            state_reg, state_next;
    logic [NDIG_BITS-1:0]  ndig_reg, ndig_next;
    logic [ADDR_BITS-1:0]  ptr_reg, ptr_next;
    logic                  out_valid_reg, out_valid_next;

    // Item payload, held for the whole conversion
    logic [RADIX_BITS-1:0] base_reg;
    logic                  upper_reg;
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] work_reg;
    logic [CHAR_BITS-1:0]  out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic [RADIX_BITS-1:0] base_sat;
    logic [VALUE_BITS-1:0] value_in;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_BITS-1:0] div_remainder;

    logic                  ram_we;
    logic                  ram_re;
    logic [DIGIT_BITS-1:0] ram_rdata;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid & item_ready;
    // The output register may take a new character when empty or draining
    assign out_free   = ~out_valid_reg | text_ready;

    // Drop the bits above the configured width
    assign value_in = value[VALUE_BITS-1:0];

    // Saturate the base into 2..36
    always_comb
    begin
        if (radix < BASE_MIN)
        begin
            base_sat = BASE_MIN;
        end
        else if (radix > BASE_MAX)
        begin
            base_sat = BASE_MAX;
        end
        else
        begin
            base_sat = radix;
        end
    end

    // Shared divider: each pass yields the next least significant digit
    irad_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Digits are stored least significant first and read back in reverse
    assign ram_we = (state_reg == S_DIV) & div_done;
    assign ram_re = (state_reg == S_READ);

    irad_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ndig_reg[ADDR_BITS-1:0]),
        .wdata (div_remainder),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        ndig_next     = ndig_reg;
        ptr_next      = ptr_reg;
        div_start     = 1'b0;
        div_dividend  = div_quotient;
        out_load      = 1'b0;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ndig_next  = '0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // Two's complement magnitude; the most negative value comes out exact
                div_start    = 1'b1;
                div_dividend = neg_reg ? (~work_reg + 1'b1) : work_reg;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    ndig_next = ndig_reg + 1'b1;
                    if (div_quotient == '0)
                    begin
                        // Zero still yields one digit, since a pass always runs
                        ptr_next   = ndig_reg[ADDR_BITS-1:0];
                        state_next = neg_reg ? S_SIGN : S_READ;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = CHAR_MINUS;
                    out_last_next = 1'b0;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                // Hold the read digit until the output register frees up
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = digit_char(ram_rdata, upper_reg);
                    out_last_next = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (text_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ndig_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ndig_reg      <= ndig_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the item on its input transfer; signed only in lowercase base 10
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg  <= base_sat;
            upper_reg <= upper_case;
            neg_reg   <= ~upper_case & (base_sat == BASE_DECIMAL) & value_in[VALUE_BITS-1];
            work_reg  <= value_in;
        end
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign text_valid = out_valid_reg;
    assign character  = out_char_reg;
    assign last       = out_last_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radix text converter
// Sends numbers with assorted bases and letter cases and works out the text
// that each should produce. Every character that leaves the block is checked
// against that text, in order, and the flag on the final character is checked
// too. Both sides idle at random, and once the output holds off for long
// enough that the input backs up.
// ----------------------------------------------------------------------------
module tb_top;

    import irad_pkg::*;

    localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
    localparam logic [VALUE_PORT_BITS-1:0] VALUE_MASK =
        (VALUE_BITS >= VALUE_PORT_BITS) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

    localparam int RANDOM_NUMBERS = 138;
    // A base-2 number of full width runs one divider pass per digit before its
    // first character appears. Allow that several times over, plus the hold-off.
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int HOLDOFF_AT     = 40;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int TAIL_CYCLES    = 300;

    typedef struct {
        logic [VALUE_PORT_BITS-1:0] value;
        logic [RADIX_BITS-1:0]      radix;
        logic                       upper_case;
    } number_item_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } text_char_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_PERIODIC
    } rx_pattern_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                       item_valid = 1'b0;
    logic                       item_ready;
    logic [VALUE_PORT_BITS-1:0] value      = '0;
    logic [RADIX_BITS-1:0]      radix      = '0;
    logic                       upper_case = 1'b0;
    logic                       text_valid;
    logic                       text_ready = 1'b0;
    logic [CHAR_BITS-1:0]       character;
    logic                       last;

    // Numbers waiting to be offered, and characters waiting to come out
    number_item_t pending_numbers[$];
    text_char_t   text_expected[$];
    text_char_t   want_char;

    int total_numbers      = 0;
    int numbers_taken      = 0;
    int characters_checked = 0;
    int negatives_seen     = 0;
    int clamped_bases      = 0;
    int error_count        = 0;
    int idle_cycles        = 0;
    logic in_fire          = 1'b0;

    // Sender burst state
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver pattern state
    rx_pattern_t rx_pattern   = RX_STEADY;
    int          pattern_left = 0;
    int          phase_count  = 0;
    int          holdoff_left = 0;
    logic        holdoff_done = 1'b0;
    logic        rx_ready;

    integer_to_ascii_radix #(
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .radix      (radix),
        .upper_case (upper_case),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .character  (character),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Text predictor: append the characters that one number turns into to the
    // store of expected text.
    // ------------------------------------------------------------------------
    function automatic void predict_text(
        input logic [VALUE_PORT_BITS-1:0] num,
        input logic [RADIX_BITS-1:0]      rad,
        input logic                       up
    );
        logic [VALUE_PORT_BITS-1:0] mag;
        logic [VALUE_PORT_BITS-1:0] base;
        logic [VALUE_PORT_BITS-1:0] rem;
        logic [CHAR_BITS-1:0]       digits[$];
        logic [CHAR_BITS-1:0]       ch;
        logic                       negative;
        int                         i;

        mag      = num & VALUE_MASK;
        negative = 1'b0;

        // Saturate the base into 2..36
        base = {{(VALUE_PORT_BITS-RADIX_BITS){1'b0}}, rad};
        if (rad < BASE_MIN || rad > BASE_MAX)
        begin
            clamped_bases++;
            base = {{(VALUE_PORT_BITS-RADIX_BITS){1'b0}},
                    ((rad < BASE_MIN) ? BASE_MIN : BASE_MAX)};
        end

        // Only lowercase decimal is signed; the magnitude of the most
        // negative value wraps back onto itself, which is what we want
        if (!up && base[RADIX_BITS-1:0] == BASE_DECIMAL && mag[VALUE_BITS-1])
        begin
            negative = 1'b1;
            negatives_seen++;
            mag = (~mag + 64'd1) & VALUE_MASK;
        end

        if (mag == '0)
        begin
            digits.push_front(CHAR_ZERO);
        end
        while (mag != '0)
        begin
            rem = mag % base;
            if (rem[CHAR_BITS-1:0] < DIGIT_TEN)
            begin
                ch = CHAR_ZERO + rem[CHAR_BITS-1:0];
            end
            else
            begin
                ch = (up ? CHAR_UPPER_A : CHAR_LOWER_A) + rem[CHAR_BITS-1:0] - DIGIT_TEN;
            end
            digits.push_front(ch);
            mag = mag / base;
        end

        if (negative)
        begin
            text_expected.push_back('{ch: CHAR_MINUS, last: 1'b0});
        end
        for (i = 0; i < digits.size(); i++)
        begin
            text_expected.push_back('{ch: digits[i], last: (i == digits.size() - 1)});
        end
    endfunction

    function automatic number_item_t random_number();
        number_item_t item;
        int unsigned  span;
        int unsigned  pick;

        // Keep most numbers short: the block spends a whole divider pass
        // per digit, so long base-2 texts are slow
        item.value = {$urandom, $urandom};
        span = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 24) : $urandom_range(0, 64);
        if (span < 64)
        begin
            item.value = item.value & ((64'd1 << span) - 64'd1);
        end
        item.upper_case = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            item.radix = RADIX_BITS'($urandom_range(0, 63));
        end
        else if (pick < 4)
        begin
            item.radix = BASE_DECIMAL;
            if (!item.upper_case && $urandom_range(0, 1) == 1)
            begin
                item.value = -item.value;
            end
        end
        else
        begin
            item.radix = RADIX_BITS'($urandom_range(BASE_MIN, BASE_MAX));
        end
        return item;
    endfunction

    task automatic add_number(
        input logic [VALUE_PORT_BITS-1:0] num,
        input logic [RADIX_BITS-1:0]      rad,
        input logic                       up
    );
        pending_numbers.push_back('{value: num, radix: rad, upper_case: up});
    endtask

    // ------------------------------------------------------------------------
    // Sender: change inputs on the falling edge. Hold valid and the payload
    // until the transfer has happened, then either rest for a gap or present
    // the next number. Bursts of random length alternate with random gaps,
    // and a gap of zero gives back-to-back offers.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !in_fire)
            begin
                // hold: the current number has not been taken yet
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_numbers.size() > 0)
            begin
                number_item_t next_item;
                next_item   = pending_numbers.pop_front();
                value      <= next_item.value;
                radix      <= next_item.radix;
                upper_case <= next_item.upper_case;
                item_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 6);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its own stall pattern, switched between steady, coin-toss and
    // periodic phases of random length. Once, after a fair number of
    // transfers in, hold ready low for a long stretch so the block backs up
    // into its input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rx_ready = 1'b0;
            end
            else if (!holdoff_done && numbers_taken >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                rx_ready     = 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    rx_pattern   = rx_pattern_t'($urandom_range(0, 2));
                    pattern_left = $urandom_range(20, 400);
                end
                pattern_left--;
                phase_count++;
                case (rx_pattern)
                    RX_STEADY:   rx_ready = 1'b1;
                    RX_COIN:     rx_ready = ($urandom_range(0, 1) == 1);
                    RX_PERIODIC: rx_ready = (phase_count % 3 != 0);
                    default:     rx_ready = 1'b1;
                endcase
            end
            text_ready <= rx_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge. Check an outgoing character against
    // the oldest expectation first, then predict the text of a number taken
    // on the same edge, so that a stray character can never match it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= item_valid && item_ready;

            if (text_valid && text_ready)
            begin
                if (text_expected.size() == 0)
                begin
                    error_count++;
                    $error("character 0x%h (last %b) with no text expected", character, last);
                end
                else
                begin
                    want_char = text_expected.pop_front();
                    characters_checked++;
                    if (character !== want_char.ch)
                    begin
                        error_count++;
                        $error("character: expected 0x%h, got 0x%h", want_char.ch, character);
                    end
                    if (last !== want_char.last)
                    begin
                        error_count++;
                        $error("last: expected %b, got %b", want_char.last, last);
                    end
                end
            end

            if (item_valid && item_ready)
            begin
                predict_text(value, radix, upper_case);
                numbers_taken <= numbers_taken + 1;
            end
        end
    end

    // Watchdog: give up when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (text_valid && text_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("[integer_to_ascii_radix] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int n;

        // Zero in both cases
        add_number(64'd0, BASE_DECIMAL, 1'b0);
        add_number(64'd0, 6'd16, 1'b1);
        // All ones: longest text in base 2, signed and unsigned in base 10,
        // and a plain pattern in lowercase hex
        add_number('1, BASE_MIN, 1'b1);
        add_number('1, BASE_DECIMAL, 1'b0);
        add_number('1, BASE_DECIMAL, 1'b1);
        add_number('1, 6'd16, 1'b0);
        // Most negative and most positive signed values
        add_number(64'h8000_0000_0000_0000, BASE_DECIMAL, 1'b0);
        add_number(64'h7fff_ffff_ffff_ffff, BASE_DECIMAL, 1'b0);
        // Negative patterns: unsigned in octal and in uppercase decimal, signed in lowercase decimal
        add_number(64'h8000_0000_0000_0000, 6'd8, 1'b0);
        add_number(-64'sd12345, BASE_DECIMAL, 1'b1);
        add_number(-64'sd12345, BASE_DECIMAL, 1'b0);
        // Bases below and above the range saturate
        add_number(64'd5, 6'd0, 1'b0);
        add_number(64'd5, 6'd1, 1'b1);
        add_number('1, 6'd37, 1'b0);
        add_number(64'd123456789, 6'd63, 1'b1);
        // Highest digits and letters in both cases
        add_number(64'd35, BASE_MAX, 1'b0);
        add_number(64'd35, BASE_MAX, 1'b1);
        add_number(64'd10, 6'd11, 1'b0);
        add_number(64'hdead_beef, 6'd16, 1'b1);
        add_number(64'h0123_4567_89ab_cdef, BASE_MAX, 1'b0);
        add_number(64'd9, BASE_DECIMAL, 1'b0);
        add_number(64'd1, BASE_MIN, 1'b0);

        for (n = 0; n < RANDOM_NUMBERS; n++)
        begin
            pending_numbers.push_back(random_number());
        end
        total_numbers = pending_numbers.size();

        // Hold reset, then release it away from the sampling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (numbers_taken != total_numbers)
        begin
            @(posedge clk);
        end
        while (text_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // Leave time for any stray character to show up
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("converted %0d numbers into %0d checked characters", total_numbers,
                 characters_checked);
        $display("%0d signed negatives, %0d bases outside 2..36, one long output hold-off",
                 negatives_seen, clamped_bases);
        if (error_count == 0)
        begin
            $display("[integer_to_ascii_radix] OK");
        end
        else
        begin
            $display("[integer_to_ascii_radix] ERROR");
        end
        $finish;
    end

endmodule
